// ===== hdl/twcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// twcs_pkg
// Shared types and constants of the textured wall column span block.
// ---------------------------------------------------------------------------
package twcs_pkg;

   // Screen rows handled at most
   localparam int unsigned MAX_ROWS = 64;

   // Field widths
   localparam int unsigned X_W    = 12;
   localparam int unsigned WH_W   = 16;
   localparam int unsigned FRAC_W = 16;
   localparam int unsigned Y_W    = 6;
   localparam int unsigned TEX_W  = 8;

   // Register file
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 13;
   localparam int unsigned SW_W       = 13;
   localparam int unsigned SH_W       = 7;
   localparam int unsigned TSIZE_W    = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXTURE_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXTURE_HEIGHT = 2'd3;

   localparam logic [SW_W-1:0]    RESET_SCREEN_WIDTH   = 13'd64;
   localparam logic [SH_W-1:0]    RESET_SCREEN_HEIGHT  = 7'd64;
   localparam logic [TSIZE_W-1:0] RESET_TEXTURE_WIDTH  = 9'd64;
   localparam logic [TSIZE_W-1:0] RESET_TEXTURE_HEIGHT = 9'd64;

   // Step divider: dividend is texture_height in Q9.16
   localparam int unsigned DIV_BITS  = TSIZE_W + 16;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_MULT,
      ST_LOAD,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // latch the request transfer
      logic setup;     // span, texture column, divider init
      logic div_step;  // one quotient bit
      logic mult;      // start position product
      logic load;      // first row and position
      logic advance;   // next row after a result transfer
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic drop;      // column yields no rows
      logic div_done;  // final quotient bit this cycle
      logic last;      // current row is the final one
   } status_type;

endpackage
`default_nettype wire

// ===== hdl/twcs_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// twcs_req_if
// Column request channel: valid/ready with the column payload.
// ---------------------------------------------------------------------------
interface twcs_req_if;
   logic                           valid;
   logic                           ready;
   logic [twcs_pkg::X_W-1:0]       column_index;
   logic [twcs_pkg::WH_W-1:0]      proj_height;
   logic [twcs_pkg::FRAC_W-1:0]    wall_fraction;

   modport source (output valid, column_index, proj_height, wall_fraction, input ready);
   modport sink   (input valid, column_index, proj_height, wall_fraction, output ready);
endinterface
`default_nettype wire

// ===== hdl/twcs_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// twcs_rsp_if
// Pixel result channel: valid/ready with the pixel payload.
// ---------------------------------------------------------------------------
interface twcs_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [twcs_pkg::X_W-1:0]    pixel_x;
   logic [twcs_pkg::Y_W-1:0]    pixel_y;
   logic [twcs_pkg::TEX_W-1:0]  texel_u;
   logic [twcs_pkg::TEX_W-1:0]  texel_v;
   logic                        last_row;

   modport source (output valid, pixel_x, pixel_y, texel_u, texel_v, last_row, input ready);
   modport sink   (input valid, pixel_x, pixel_y, texel_u, texel_v, last_row, output ready);
endinterface
`default_nettype wire

// ===== hdl/twcs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// twcs_ctrl
// Sequencer: capture, setup, divide, multiply, load, then emit rows; a dropped column ends after setup.
// ---------------------------------------------------------------------------
module twcs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  rsp_ready,
   input  twcs_pkg::status_type  status,
   output logic                  req_ready,
   output logic                  rsp_valid,
   output twcs_pkg::cmd_type     cmd
);

   twcs_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= twcs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         twcs_pkg::ST_IDLE: begin
            if (req_valid) state_in = twcs_pkg::ST_SETUP;
         end
         twcs_pkg::ST_SETUP: begin
            if (status.drop) state_in = twcs_pkg::ST_IDLE;
            else state_in = twcs_pkg::ST_DIVIDE;
         end
         twcs_pkg::ST_DIVIDE: begin
            if (status.div_done) state_in = twcs_pkg::ST_MULT;
         end
         twcs_pkg::ST_MULT: begin
            state_in = twcs_pkg::ST_LOAD;
         end
         twcs_pkg::ST_LOAD: begin
            state_in = twcs_pkg::ST_EMIT;
         end
         twcs_pkg::ST_EMIT: begin
            if (rsp_ready && status.last) state_in = twcs_pkg::ST_IDLE;
         end
         default: begin
            state_in = twcs_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs; hold off requests while in reset
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         twcs_pkg::ST_IDLE: begin
            req_ready   = ~reset;
            cmd.capture = req_valid & ~reset;
         end
         twcs_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         twcs_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         twcs_pkg::ST_MULT: begin
            cmd.mult = 1'b1;
         end
         twcs_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
         end
         twcs_pkg::ST_EMIT: begin
            rsp_valid   = 1'b1;
            cmd.advance = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== hdl/twcs_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// twcs_datapath
// Registers, span math, bit-serial step divider, position multiplier and
// row accumulator of the wall column.
// ---------------------------------------------------------------------------
module twcs_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  twcs_pkg::cmd_type                  cmd,
   output twcs_pkg::status_type               status,
   // Register writes
   input  logic                               csr_write_enable,
   input  logic [twcs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [twcs_pkg::CSR_DATA_W-1:0]    csr_write_data,
   // Request payload
   input  logic [twcs_pkg::X_W-1:0]           column_index,
   input  logic [twcs_pkg::WH_W-1:0]          proj_height,
   input  logic [twcs_pkg::FRAC_W-1:0]        wall_fraction,
   // Result payload
   output logic [twcs_pkg::X_W-1:0]           pixel_x,
   output logic [twcs_pkg::Y_W-1:0]           pixel_y,
   output logic [twcs_pkg::TEX_W-1:0]         texel_u,
   output logic [twcs_pkg::TEX_W-1:0]         texel_v,
   output logic                               last_row
);

   localparam int unsigned S_W    = twcs_pkg::WH_W + 2;   // signed span math
   localparam int unsigned Q_W    = twcs_pkg::DIV_BITS;
   localparam int unsigned PROD_W = S_W + Q_W + 1;
   localparam int unsigned POS_W  = 32;
   localparam int unsigned IP_W   = 15;                    // integer part of position

   // Clamp an index to size - 1 and to the texel range; zero size gives zero
   function automatic logic [twcs_pkg::TEX_W-1:0] clamp_index(
      input logic [IP_W-1:0]                   v,
      input logic [twcs_pkg::TSIZE_W-1:0]      size
   );
      logic [IP_W-1:0] top;
      logic [IP_W-1:0] r;
      top = IP_W'(size) - IP_W'(1);
      r   = v;
      if (r > top) r = top;
      if (r > IP_W'(255)) r = IP_W'(255);
      if (size == '0) r = '0;
      return r[twcs_pkg::TEX_W-1:0];
   endfunction

   function automatic logic [twcs_pkg::TSIZE_W+twcs_pkg::FRAC_W-1:0] wall_fraction_mul(
      input logic [twcs_pkg::FRAC_W-1:0]  f,
      input logic [twcs_pkg::TSIZE_W-1:0] w
   );
      return (twcs_pkg::TSIZE_W+twcs_pkg::FRAC_W)'(f) *
             (twcs_pkg::TSIZE_W+twcs_pkg::FRAC_W)'(w);
   endfunction

   function automatic logic [twcs_pkg::SW_W-1:0] SW_W_ext(input logic [twcs_pkg::X_W-1:0] v);
      return twcs_pkg::SW_W'(v);
   endfunction

   // Configuration
   logic [twcs_pkg::SW_W-1:0]    screen_width_ff;
   logic [twcs_pkg::SH_W-1:0]    screen_height_ff;
   logic [twcs_pkg::TSIZE_W-1:0] texture_width_ff;
   logic [twcs_pkg::TSIZE_W-1:0] texture_height_ff;

   // Captured request
   logic [twcs_pkg::X_W-1:0]     x_ff;
   logic [twcs_pkg::WH_W-1:0]    wh_ff;
   logic [twcs_pkg::FRAC_W-1:0]  frac_ff;

   // Span and texture column
   logic [twcs_pkg::Y_W-1:0]     first_ff;
   logic [twcs_pkg::Y_W-1:0]     last_ff;
   logic signed [S_W-1:0]        d_ff;
   logic [twcs_pkg::TEX_W-1:0]   u_ff;

   // Divider
   logic [twcs_pkg::WH_W-1:0]      rem_ff, rem_in;
   logic [Q_W-1:0]                 qn_ff, qn_in;
   logic [twcs_pkg::DIV_CNT_W-1:0] cnt_ff;

   // Position
   logic [PROD_W-1:0]            prod_ff;
   logic [POS_W-1:0]             step_ff;
   logic [POS_W-1:0]             pos_ff;
   logic [twcs_pkg::Y_W-1:0]     y_ff;

   // Status to the sequencer
   logic                         drop_c;
   logic                         div_done_c;
   logic                         row_last;

   assign status = '{drop: drop_c, div_done: div_done_c, last: row_last};

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff   <= twcs_pkg::RESET_SCREEN_WIDTH;
         screen_height_ff  <= twcs_pkg::RESET_SCREEN_HEIGHT;
         texture_width_ff  <= twcs_pkg::RESET_TEXTURE_WIDTH;
         texture_height_ff <= twcs_pkg::RESET_TEXTURE_HEIGHT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            twcs_pkg::CSR_SCREEN_WIDTH:   screen_width_ff   <= csr_write_data;
            twcs_pkg::CSR_SCREEN_HEIGHT:  screen_height_ff  <= csr_write_data[twcs_pkg::SH_W-1:0];
            twcs_pkg::CSR_TEXTURE_WIDTH:  texture_width_ff  <= csr_write_data[twcs_pkg::TSIZE_W-1:0];
            twcs_pkg::CSR_TEXTURE_HEIGHT: texture_height_ff <= csr_write_data[twcs_pkg::TSIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Span: centre in half pixels, clip to the screen
   logic [twcs_pkg::SH_W-1:0]     sh;
   logic signed [S_W-1:0]         s2;
   logic signed [S_W-1:0]         first_raw;
   logic [twcs_pkg::Y_W-1:0]      first_c;
   logic [S_W-1:0]                half_sum;
   logic [S_W-1:0]                last_raw;
   logic [S_W-1:0]                sh_top;
   logic [twcs_pkg::Y_W-1:0]      last_c;
   logic signed [S_W-1:0]         d_c;
   logic [twcs_pkg::TSIZE_W+twcs_pkg::FRAC_W-1:0] u_prod;
   logic [twcs_pkg::TEX_W-1:0]    u_c;

   always_comb begin
      sh = (screen_height_ff > twcs_pkg::SH_W'(twcs_pkg::MAX_ROWS))
         ? twcs_pkg::SH_W'(twcs_pkg::MAX_ROWS) : screen_height_ff;
      s2        = $signed(S_W'(sh)) - $signed(S_W'(wh_ff));
      first_raw = s2 >>> 1;
      first_c   = first_raw[S_W-1] ? '0 : first_raw[twcs_pkg::Y_W-1:0];
      half_sum  = (S_W'(sh) + S_W'(wh_ff) + S_W'(1)) >> 1;
      last_raw  = half_sum - S_W'(1);
      sh_top    = S_W'(sh) - S_W'(1);
      last_c    = (last_raw > sh_top) ? sh_top[twcs_pkg::Y_W-1:0]
                                      : last_raw[twcs_pkg::Y_W-1:0];
      d_c       = $signed(S_W'({first_c, 1'b0})) - s2;
      u_prod    = wall_fraction_mul(frac_ff, texture_width_ff);
      u_c       = clamp_index(IP_W'(u_prod[twcs_pkg::TSIZE_W+twcs_pkg::FRAC_W-1:16]),
                              texture_width_ff);
      drop_c    = (SW_W_ext(x_ff) >= screen_width_ff) || (wh_ff == '0) ||
                  (sh == '0) || (last_c < first_c);
   end

   // Divider step: restoring, one quotient bit per cycle
   logic [twcs_pkg::WH_W:0] trial;
   logic                    qbit;

   always_comb begin
      trial      = {rem_ff, qn_ff[Q_W-1]};
      qbit       = (trial >= {1'b0, wh_ff});
      rem_in     = qbit ? twcs_pkg::WH_W'(trial - {1'b0, wh_ff}) : trial[twcs_pkg::WH_W-1:0];
      qn_in      = {qn_ff[Q_W-2:0], qbit};
      div_done_c = (cnt_ff == twcs_pkg::DIV_CNT_W'(Q_W - 1));
   end

   // Position product: (2 * first - s2) * step
   logic signed [PROD_W-1:0] prod_full;
   assign prod_full = $signed(PROD_W'(d_ff)) * $signed(PROD_W'({1'b0, qn_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.setup) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + twcs_pkg::DIV_CNT_W'(1);
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      // Hold the request transfer
      if (cmd.capture) begin
         x_ff    <= column_index;
         wh_ff   <= proj_height;
         frac_ff <= wall_fraction;
      end
      // Latch span, texture column; load the dividend
      if (cmd.setup) begin
         first_ff <= first_c;
         last_ff  <= last_c;
         d_ff     <= d_c;
         u_ff     <= u_c;
         rem_ff   <= '0;
         qn_ff    <= {texture_height_ff, 16'd0};
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         qn_ff  <= qn_in;
      end
      if (cmd.mult) begin
         prod_ff <= prod_full;
         step_ff <= POS_W'(qn_ff);
      end
      // Floor halve the product for the starting position
      if (cmd.load) begin
         pos_ff <= prod_ff[POS_W:1];
         y_ff   <= first_ff;
      end
      // Advance to the next row
      if (cmd.advance) begin
         pos_ff <= pos_ff + step_ff;
         y_ff   <= y_ff + twcs_pkg::Y_W'(1);
      end
   end

   // Result payload
   always_comb begin
      row_last    = (y_ff == last_ff);
      pixel_x     = x_ff;
      pixel_y     = y_ff;
      texel_u     = u_ff;
      texel_v     = pos_ff[POS_W-1] ? '0
                  : clamp_index(pos_ff[POS_W-2:16], texture_height_ff);
      last_row    = row_last;
   end

endmodule
`default_nettype wire

// ===== hdl/textured_wall_column_span.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// textured_wall_column_span
// One textured wall column of a ray caster: centres and clips a wall span,
// derives the texture column and a Q16.16 texture step, then streams one
// pixel per drawn row.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   req_bus   in         column_index, proj_height, wall_fraction
//   rsp_bus   out        pixel_x, pixel_y, texel_u, texel_v, last_row
//   csr_*     in         write enable, register index, write data
//
// A column passes through setup, the bit-serial step divider, the position
// product and the start load, then emits one row per cycle while rsp_bus is
// ready (up to 64 rows). A dropped column returns to idle after setup.
// Reset is synchronous and restores the configuration registers to 64; no
// clearing pass. A stalled result holds the row; the next request is taken
// after the last row transfer.
// ---------------------------------------------------------------------------
module textured_wall_column_span (
   input  logic                                   clock,
   input  logic                                   reset,
   twcs_req_if.sink                               req_bus,
   twcs_rsp_if.source                             rsp_bus,
   input  logic                                   csr_write_enable,
   input  logic [twcs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [twcs_pkg::CSR_DATA_W-1:0]        csr_write_data
);

   twcs_pkg::cmd_type    cmd;
   twcs_pkg::status_type status;

   // Sequencer
   twcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .cmd       (cmd)
   );

   // Datapath
   twcs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .column_index     (req_bus.column_index),
      .proj_height      (req_bus.proj_height),
      .wall_fraction    (req_bus.wall_fraction),
      .pixel_x          (rsp_bus.pixel_x),
      .pixel_y          (rsp_bus.pixel_y),
      .texel_u          (rsp_bus.texel_u),
      .texel_v          (rsp_bus.texel_v),
      .last_row         (rsp_bus.last_row)
   );

endmodule
`default_nettype wire
